FILE: hw/rtl/pas_pkg.sv
`default_nettype none

package pas_pkg;

    // Arrival ring depth
    localparam int WINDOW = 20;

    // Ring index and fill count widths
    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);

    // Rate numerator is count * 1000 Hz * 256 (Q.8)
    localparam int RATE_SCALE = 256000;
    localparam int NUM_W      = $clog2(WINDOW * RATE_SCALE + 1);
    localparam int STEP_W     = $clog2(NUM_W);

    localparam logic [23:0] RATE_MAX = 24'hFFFFFF;
    localparam logic [15:0] SEQ_MASK = 16'hFFFF;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pas_in_if.sv
`default_nettype none

interface pas_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] seq_number;
    logic [31:0] arrival_time_ms;

    modport source (output valid, output seq_number, output arrival_time_ms, input ready);
    modport sink   (input valid, input seq_number, input arrival_time_ms, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pas_out_if.sv
`default_nettype none

interface pas_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] age_ms;
    logic [23:0] rate_q8;
    logic        has_gap;
    logic [15:0] exp_seq;
    logic [15:0] rx_seq;
    logic [15:0] lost_count;

    modport source (
        output valid, output age_ms, output rate_q8, output has_gap,
        output exp_seq, output rx_seq, output lost_count,
        input  ready
    );
    modport sink (
        input  valid, input age_ms, input rate_q8, input has_gap,
        input  exp_seq, input rx_seq, input lost_count,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/packet_arrival_statistics.sv
`default_nettype none

// Packet arrival statistics. Each arrival beat (sequence number, millisecond
// timestamp) yields one stats beat: age since the previous arrival, rolling
// rate over the last WINDOW arrivals in Q.8 Hz, and sequence gap information.
// An arrival passes through the sequencer states LOAD, DIV and DONE before the
// block is ready again; DIV runs the radix-2 restoring divider, which produces
// one quotient bit per cycle of the rate numerator count * 256000. When the
// window holds no entries or its span is zero the divider is skipped and the
// previous rate is reported. A finished beat sits in an output register, so the
// next arrival is accepted while it waits; the block stalls only if a second
// result is done before the first is taken.

module packet_arrival_statistics (
    input  wire logic clk,
    input  wire logic rst_n,
    pas_in_if.sink    arrival,
    pas_out_if.source stats
);
    import pas_pkg::*;

    state_t state_reg;

    // Architectural state
    logic [IDX_W-1:0] ring_head_reg;
    logic [CNT_W-1:0] ring_count_reg;
    logic [23:0]      held_rate_reg;
    logic [15:0]      next_expected_reg;
    logic [31:0]      last_arrival_reg;
    logic             seen_any_reg;

    // Arrival ring memory
    logic [31:0] ring_mem [WINDOW];
    logic [31:0] ring_rd_reg;

    // Per-item working registers
    logic [31:0] now_reg;
    logic [31:0] age_reg;
    logic        gap_reg;
    logic [15:0] expected_reg;
    logic [15:0] seq_reg;
    logic [15:0] missed_reg;
    logic        div_run_reg;

    // Divider registers
    logic [31:0]       span_reg;
    logic [31:0]       rem_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [STEP_W-1:0] step_reg;

    // Output register
    logic        out_valid_reg;
    logic [31:0] out_age_reg;
    logic [23:0] out_rate_reg;
    logic        out_gap_reg;
    logic [15:0] out_expected_reg;
    logic [15:0] out_seq_reg;
    logic [15:0] out_missed_reg;

    logic accept;
    logic out_free;
    logic finish;

    assign arrival.ready = (state_reg == S_IDLE);
    assign accept        = arrival.valid && arrival.ready;
    assign out_free      = !out_valid_reg || stats.ready;
    assign finish        = (state_reg == S_DONE) && out_free;

    // Oldest ring slot: (head + WINDOW - count) mod WINDOW
    logic [CNT_W:0]   oldest_sum;
    logic [IDX_W-1:0] oldest_slot;

    always_comb
    begin
        oldest_sum = (CNT_W+1)'(ring_head_reg) + (CNT_W+1)'(WINDOW)
                   - (CNT_W+1)'(ring_count_reg);
        if (oldest_sum >= (CNT_W+1)'(WINDOW))
        begin
            oldest_sum = oldest_sum - (CNT_W+1)'(WINDOW);
        end
        oldest_slot = oldest_sum[IDX_W-1:0];
    end

    // Span of the window as seen from the ring read
    logic [31:0] span_now;
    assign span_now = now_reg - ring_rd_reg;

    // Rate numerator
    logic [NUM_W-1:0] num_init;
    assign num_init = NUM_W'(ring_count_reg * RATE_SCALE);

    // One restoring division step
    logic [32:0]      rem_shift;
    logic             rem_ge;
    logic [31:0]      rem_step;
    logic [NUM_W-1:0] quo_step;

    always_comb
    begin
        rem_shift = {rem_reg, num_reg[NUM_W-1]};
        rem_ge    = (rem_shift >= {1'b0, span_reg});
        rem_step  = rem_ge ? 32'(rem_shift - {1'b0, span_reg}) : rem_shift[31:0];
        quo_step  = {quo_reg[NUM_W-2:0], rem_ge};
    end

    // Saturated quotient
    logic [23:0] rate_sat;
    assign rate_sat = (32'(quo_reg) > 32'(RATE_MAX)) ? RATE_MAX : 24'(quo_reg);

    // Sequence check on the incoming beat
    logic        gap_in;
    logic [31:0] age_in;

    always_comb
    begin
        gap_in = seen_any_reg && (arrival.seq_number != next_expected_reg);
        age_in = '0;
        if (seen_any_reg && (arrival.arrival_time_ms >= last_arrival_reg))
        begin
            age_in = arrival.arrival_time_ms - last_arrival_reg;
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    if ((ring_count_reg != '0) && (span_now != '0))
                    begin
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DIV:
                begin
                    if (step_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Architectural state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_head_reg     <= '0;
            ring_count_reg    <= '0;
            held_rate_reg     <= '0;
            next_expected_reg <= '0;
            last_arrival_reg  <= '0;
            seen_any_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                next_expected_reg <= (arrival.seq_number + 16'd1) & SEQ_MASK;
                last_arrival_reg  <= arrival.arrival_time_ms;
                seen_any_reg      <= 1'b1;
            end
            if (finish)
            begin
                if (div_run_reg)
                begin
                    held_rate_reg <= rate_sat;
                end
                if (ring_head_reg == IDX_W'(WINDOW - 1))
                begin
                    ring_head_reg <= '0;
                end
                else
                begin
                    ring_head_reg <= ring_head_reg + IDX_W'(1);
                end
                if (ring_count_reg != CNT_W'(WINDOW))
                begin
                    ring_count_reg <= ring_count_reg + CNT_W'(1);
                end
            end
        end
    end

    // Ring read at accept, write when the item retires
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_rd_reg <= ring_mem[oldest_slot];
        end
        if (finish)
        begin
            ring_mem[ring_head_reg] <= now_reg;
        end
    end

    // Per-item capture and divider datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_run_reg <= 1'b0;
            step_reg    <= '0;
        end
        else
        begin
            if (state_reg == S_LOAD)
            begin
                div_run_reg <= (ring_count_reg != '0) && (span_now != '0);
                step_reg    <= STEP_W'(NUM_W - 1);
            end
            else if ((state_reg == S_DIV) && (step_reg != '0))
            begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg      <= arrival.arrival_time_ms;
            age_reg      <= age_in;
            gap_reg      <= gap_in;
            expected_reg <= next_expected_reg;
            seq_reg      <= arrival.seq_number;
            missed_reg   <= gap_in ? ((arrival.seq_number - next_expected_reg) & SEQ_MASK)
                                   : 16'd0;
        end
        if (state_reg == S_LOAD)
        begin
            span_reg <= span_now;
            rem_reg  <= '0;
            num_reg  <= num_init;
            quo_reg  <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            rem_reg <= rem_step;
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            quo_reg <= quo_step;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (stats.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_age_reg      <= age_reg;
            out_rate_reg     <= div_run_reg ? rate_sat : held_rate_reg;
            out_gap_reg      <= gap_reg;
            out_expected_reg <= expected_reg;
            out_seq_reg      <= seq_reg;
            out_missed_reg   <= missed_reg;
        end
    end

    assign stats.valid      = out_valid_reg;
    assign stats.age_ms     = out_age_reg;
    assign stats.rate_q8    = out_rate_reg;
    assign stats.has_gap    = out_gap_reg;
    assign stats.exp_seq    = out_expected_reg;
    assign stats.rx_seq     = out_seq_reg;
    assign stats.lost_count = out_missed_reg;

    // Checks
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_LOAD))
        else $error("accepted beat did not start the ring read");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DIV) && (step_reg == '0)) |=> (state_reg == S_DONE))
        else $error("divider did not retire after its last step");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (stats.valid && (state_reg == S_IDLE)))
        else $error("retired item did not reach the output register");

    a_count_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (ring_count_reg != '0) |-> seen_any_reg)
        else $error("ring holds entries before any arrival");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (ring_count_reg <= CNT_W'(WINDOW)))
        else $error("ring count overran the window");

endmodule

`default_nettype wire

FILE: verif/pas_checker.sv
`timescale 1ns / 100ps

// Watches both channels: predicts the stats beat for every accepted arrival
// and compares it with what the block returns, in order.
module pas_checker (
    input  logic clk,
    input  logic rst_n,
    pas_in_if    arrival,
    pas_out_if   stats,
    output int   mismatches,
    output int   pending,
    output int   results_seen,
    output int   gaps_seen,
    output int   backward_seen,
    output int   held_seen
);
    import pas_pkg::*;

    typedef struct packed {
        logic [31:0] age_ms;
        logic [23:0] rate_q8;
        logic        has_gap;
        logic [15:0] exp_seq;
        logic [15:0] rx_seq;
        logic [15:0] lost_count;
    } stats_beat_t;

    // Shadow copy of the monitor state
    logic [31:0] arrival_ring [WINDOW];
    int          ring_count;
    int          ring_head;
    logic [23:0] held_rate;
    logic [15:0] next_expected;
    logic [31:0] last_arrival;
    logic        seen_any;

    stats_beat_t expected_stats_q [$];

    int n_bad      = 0;
    int n_results  = 0;
    int n_gaps     = 0;
    int n_backward = 0;
    int n_held     = 0;

    assign mismatches    = n_bad;
    assign results_seen  = n_results;
    assign gaps_seen     = n_gaps;
    assign backward_seen = n_backward;
    assign held_seen     = n_held;

    // Advance the shadow state by one arrival and return the stats it yields
    function automatic stats_beat_t predict_stats(input logic [15:0] seq,
                                                  input logic [31:0] now);
        stats_beat_t beat;
        logic [31:0] span;
        logic [63:0] quotient;
        int          oldest;
        beat = '0;
        beat.exp_seq = next_expected;
        beat.rx_seq  = seq;

        if (seen_any && now >= last_arrival)
            beat.age_ms = now - last_arrival;
        if (seen_any && now < last_arrival)
            n_backward++;

        // rate over the window; zero span keeps the old rate
        if (ring_count > 0)
        begin
            oldest = (ring_head + WINDOW - ring_count) % WINDOW;
            span   = now - arrival_ring[oldest];
            if (span != 32'd0)
            begin
                quotient  = (64'(ring_count) * 64'(RATE_SCALE)) / 64'(span);
                held_rate = (quotient > 64'(RATE_MAX)) ? RATE_MAX : quotient[23:0];
            end
            else
                n_held++;
        end
        arrival_ring[ring_head] = now;
        ring_head = (ring_head + 1) % WINDOW;
        if (ring_count < WINDOW)
            ring_count++;
        beat.rate_q8 = held_rate;

        // sequence check, missed count wraps mod 2^16
        if (seen_any && seq != next_expected)
        begin
            beat.has_gap    = 1'b1;
            beat.lost_count = seq - next_expected;
            n_gaps++;
        end

        next_expected = seq + 16'd1;
        last_arrival  = now;
        seen_any      = 1'b1;
        return beat;
    endfunction

    // Compare returned beats first, then queue the prediction for a new arrival
    always @(posedge clk or negedge rst_n)
    begin
        stats_beat_t got;
        stats_beat_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
                arrival_ring[i] = '0;
            ring_count    = 0;
            ring_head     = 0;
            held_rate     = '0;
            next_expected = '0;
            last_arrival  = '0;
            seen_any      = 1'b0;
            expected_stats_q.delete();
            pending <= 0;
        end
        else
        begin
            if (stats.valid && stats.ready)
            begin
                got = '{age_ms:     stats.age_ms,
                        rate_q8:    stats.rate_q8,
                        has_gap:    stats.has_gap,
                        exp_seq:    stats.exp_seq,
                        rx_seq:     stats.rx_seq,
                        lost_count: stats.lost_count};
                n_results++;
                if (expected_stats_q.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("%0t: stats beat with no arrival pending: seq=%h age=%0d",
                                 $realtime, got.rx_seq, got.age_ms);
                end
                else
                begin
                    want = expected_stats_q.pop_front();
                    if (got !== want)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                        begin
                            $display("%0t: stats mismatch (age rate gap exp rcv missed)",
                                     $realtime);
                            $display("  expected %0d %h %b %h %h %h", want.age_ms,
                                     want.rate_q8, want.has_gap, want.exp_seq,
                                     want.rx_seq, want.lost_count);
                            $display("  actual   %0d %h %b %h %h %h", got.age_ms,
                                     got.rate_q8, got.has_gap, got.exp_seq,
                                     got.rx_seq, got.lost_count);
                        end
                    end
                end
            end
            if (arrival.valid && arrival.ready)
                expected_stats_q.push_back(predict_stats(arrival.seq_number,
                                                         arrival.arrival_time_ms));
            pending <= expected_stats_q.size();
        end
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import pas_pkg::*;

    typedef enum int {
        PROF_IN_ORDER,
        PROF_SAME_TIME,
        PROF_LONG_GAP,
        PROF_JITTER,
        PROF_NOISE
    } profile_t;

    localparam int RANDOM_BEATS = 1926;
    localparam int CALM_AFTER   = 1600;

    logic clk;
    logic rst_n;
    logic idle_on = 1'b1;

    int mismatches;
    int pending;
    int results_seen;
    int gaps_seen;
    int backward_seen;
    int held_seen;

    pas_in_if  arrival_if ();
    pas_out_if stats_if ();

    packet_arrival_statistics uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .arrival (arrival_if),
        .stats   (stats_if)
    );

    pas_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .arrival       (arrival_if),
        .stats         (stats_if),
        .mismatches    (mismatches),
        .pending       (pending),
        .results_seen  (results_seen),
        .gaps_seen     (gaps_seen),
        .backward_seen (backward_seen),
        .held_seen     (held_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #(10_000_000);
        $display("packet_arrival_statistics regression: fail");
        $finish;
    end

    // Stats sink: random stall bursts while idling is enabled
    initial
    begin
        stats_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stats_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            stats_if.ready <= 1'b1;
        end
    end

    // Present one arrival beat, optionally after an idle burst
    task automatic send_arrival(input logic [15:0] seq, input logic [31:0] now);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            arrival_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        arrival_if.valid           <= 1'b1;
        arrival_if.seq_number      <= seq;
        arrival_if.arrival_time_ms <= now;
        do
            @(posedge clk);
        while (arrival_if.ready !== 1'b1);
    endtask

    // Stop sending and wait for every outstanding stats beat
    task automatic drain_results;
        arrival_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] seq_cursor;
        logic [31:0] time_cursor;
        profile_t    profile;
        int          sent;
        int          burst;
        int          pick;

        arrival_if.valid           <= 1'b0;
        arrival_if.seq_number      <= '0;
        arrival_if.arrival_time_ms <= '0;
        rst_n                      <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first packet, wraps, zero span, backwards time, gaps
        send_arrival(16'hFFFF, 32'hFFFF_FFF0);  // first packet, never a gap
        send_arrival(16'h0000, 32'hFFFF_FFF0);  // seq wrap, same time -> rate held
        send_arrival(16'h0001, 32'hFFFF_FFFF);
        send_arrival(16'h0002, 32'h0000_0000);  // clock wrap looks backwards
        send_arrival(16'h8000, 32'h0000_0001);  // forward gap
        send_arrival(16'h0000, 32'h0000_0001);  // gap with wrapped missed count
        send_arrival(16'h0000, 32'h8000_0000);  // duplicate, huge span
        send_arrival(16'h0001, 32'h7FFF_FFFF);  // backwards
        // fill the window with tight spacing for a high rate
        for (int i = 0; i < WINDOW - 4; i++)
            send_arrival(16'(i + 2), 32'h8000_0000 + 32'(i));

        // Hold off until the block has returned everything
        drain_results();

        // Random: mostly in-order streams, some bursty, jittered and noise beats
        seq_cursor  = 16'($urandom);
        time_cursor = $urandom;
        sent        = 0;
        while (sent < RANDOM_BEATS)
        begin
            pick    = $urandom_range(0, 9);
            profile = (pick < 6) ? PROF_IN_ORDER : profile_t'(pick - 5);
            burst   = $urandom_range(5, 60);
            for (int k = 0; k < burst && sent < RANDOM_BEATS; k++)
            begin
                if (sent == CALM_AFTER)
                    idle_on <= 1'b0;
                case (profile)
                    PROF_IN_ORDER:
                    begin
                        if ($urandom_range(0, 15) == 0)
                            seq_cursor = seq_cursor + 16'($urandom_range(1, 300));
                        time_cursor = time_cursor + $urandom_range(0, 40);
                    end
                    PROF_SAME_TIME:
                    begin
                        if ($urandom_range(0, 7) == 0)
                            time_cursor = time_cursor + $urandom_range(1, 3);
                    end
                    PROF_LONG_GAP:
                        time_cursor = time_cursor + $urandom;
                    PROF_JITTER:
                    begin
                        if ($urandom_range(0, 7) == 0)
                            seq_cursor = seq_cursor - 16'd1;
                        time_cursor = time_cursor + $urandom_range(0, 60) - 32'd30;
                    end
                    default:
                    begin
                        seq_cursor  = 16'($urandom);
                        time_cursor = $urandom;
                    end
                endcase
                send_arrival(seq_cursor, time_cursor);
                seq_cursor = seq_cursor + 16'd1;
                sent++;
            end
        end

        drain_results();
        repeat (40) @(posedge clk);

        $display("covered %0d stats beats: %0d sequence gaps, %0d backward timestamps,",
                 results_seen, gaps_seen, backward_seen);
        $display("%0d zero-span rate holds, %0d mismatches", held_seen, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("packet_arrival_statistics regression: pass");
        else
            $display("packet_arrival_statistics regression: fail");
        $finish;
    end

endmodule
